### design/bilinear_image_sampler_unit_macros.svh
// assertion macros shared by the sampler checker
// no dependencies; included by bis_checker.sv
`ifndef BILINEAR_IMAGE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_IMAGE_SAMPLER_UNIT_MACROS_SVH

// property checked only while out of reset
`define BIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BIS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/bis_pkg.sv
// shared types and constants of the bilinear image sampler
// no dependencies
`timescale 1ns / 1ps

package bis_pkg;

    localparam int NUM_BANKS  = 4;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 17;
    localparam int OUT_FRAC   = 16;
    localparam int OUT_W      = 24;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

    // item modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // bank control from the sampler front end to the pixel banks
    typedef struct packed {
        logic       wr_en;
        logic [1:0] wr_bank;
        logic       rd_en;
    } t_bank_ctl;

endpackage

### design/bilinear_image_sampler_unit.sv
// top level of the bilinear image sampler: config registers, bounds check,
// bank addressing and the blend pipeline; depends on bis_pkg, bis_pixel_banks
`timescale 1ns / 1ps

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+---------------------------------------
// input    | in        | i_in_valid / o_in_ready    | mode, pixel column/row/value, u, v
// result   | out       | o_out_valid / i_out_ready  | sample_value, in_bounds
// config   | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// one item per cycle unless a stalled result backs up every stage; the four
// pixel banks are read together, so a sample costs one read port slot and a write costs one write slot
// a sample result passes the bank read, horizontal blend, vertical blend and
// output register in that order after its item is taken; a write gives no result
// reset clears the pipeline valids and sets both dimensions to 256; the pixel
// store is not cleared and holds garbage until written
// a stalled result stays in the output register; the stages behind it keep
// closing gaps, and input is held off only when every stage is full

module bilinear_image_sampler_unit
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [7:0]                  i_pixel_column,
    input  logic [7:0]                  i_pixel_row,
    input  logic [PIX_W-1:0]            i_pixel_value,
    input  logic signed [COORD_W-1:0]   i_u_pos,
    input  logic signed [COORD_W-1:0]   i_v_pos,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [OUT_W-1:0]            o_sample_value,
    output logic                        o_in_bounds
);

    // half-resolution address widths: each bank holds one parity class
    localparam int HCW = (MAX_WIDTH > 2)  ? $clog2(MAX_WIDTH) - 1  : 1;
    localparam int HRW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) - 1 : 1;
    localparam int BAW = HCW + HRW;

    // integer part of a non-negative coordinate
    localparam int XW = COORD_W - 1 - FRAC_BITS;

    // weight, horizontal blend and accumulator widths
    localparam int FW = FRAC_BITS + 1;
    localparam int HW = FRAC_BITS + PIX_W;
    localparam int AW = 2 * FRAC_BITS + PIX_W;
    localparam int PF = 2 * FRAC_BITS;

    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_width_in_use;
    logic [CFG_W-1:0] r_height_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_in_use  <= DIM_RESET;
            r_height_in_use <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH_IN_USE:  r_width_in_use  <= i_cfg_data;
                REG_HEIGHT_IN_USE: r_height_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow: each stage moves when the one ahead is empty or moving
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic s3_move, s2_move, s1_move;
    logic s3_free, s2_free, s1_free;

    assign s3_move = r_s3_valid && (!r_out_valid || i_out_ready);
    assign s3_free = !r_s3_valid || s3_move;
    assign s2_move = r_s2_valid && s3_free;
    assign s2_free = !r_s2_valid || s2_move;
    assign s1_move = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s1_move;

    assign o_in_ready = s1_free;

    logic in_take, smp_take, wr_take;
    assign in_take  = i_in_valid && o_in_ready;
    assign smp_take = in_take && (i_mode == MODE_SAMPLE);
    // writes outside the store are dropped
    assign wr_take  = in_take && (i_mode == MODE_WRITE)
                      && (32'(i_pixel_column) < MAX_WIDTH)
                      && (32'(i_pixel_row) < MAX_HEIGHT);

    // ------------------------------------------------------------------
    // sample front end: floor, fraction, bounds and bank addresses
    // ------------------------------------------------------------------
    logic [XW-1:0]        smp_x, smp_y;
    logic [FRAC_BITS-1:0] smp_a, smp_b;
    logic                 smp_inb;
    logic [HCW-1:0]       col_even, col_odd;
    logic [HRW-1:0]       row_even, row_odd;
    logic [BAW-1:0]       rd_addr [NUM_BANKS];
    logic [BAW-1:0]       wr_addr;
    t_bank_ctl            bank_ctl;

    assign smp_x = i_u_pos[COORD_W-2:FRAC_BITS];
    assign smp_y = i_v_pos[COORD_W-2:FRAC_BITS];
    assign smp_a = i_u_pos[FRAC_BITS-1:0];
    assign smp_b = i_v_pos[FRAC_BITS-1:0];

    // x + 1 and y + 1 must stay below both the register and the store size
    assign smp_inb = !i_u_pos[COORD_W-1] && !i_v_pos[COORD_W-1]
                     && (32'(smp_x) + 32'd1 < 32'(r_width_in_use))
                     && (32'(smp_x) + 32'd1 < MAX_WIDTH)
                     && (32'(smp_y) + 32'd1 < 32'(r_height_in_use))
                     && (32'(smp_y) + 32'd1 < MAX_HEIGHT);

    // of x and x+1 one is even and one odd; the even one is x or x+1
    assign col_odd  = HCW'(smp_x >> 1);
    assign col_even = HCW'((smp_x >> 1) + XW'(smp_x[0]));
    assign row_odd  = HRW'(smp_y >> 1);
    assign row_even = HRW'((smp_y >> 1) + XW'(smp_y[0]));

    // bank k holds row parity k[1] and column parity k[0]
    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            rd_addr[k] = {(k[1] ? row_odd : row_even), (k[0] ? col_odd : col_even)};
        end
    end

    assign wr_addr = {HRW'(i_pixel_row >> 1), HCW'(i_pixel_column >> 1)};

    assign bank_ctl.wr_en   = wr_take;
    assign bank_ctl.wr_bank = {i_pixel_row[0], i_pixel_column[0]};
    assign bank_ctl.rd_en   = smp_take;

    logic [PIX_W-1:0] bank_data [NUM_BANKS];

    bis_pixel_banks #(
        .ADDR_W (BAW)
    ) u_bis_pixel_banks (
        .i_clk     (i_clk),
        .i_ctl     (bank_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_pixel_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (bank_data)
    );

    // ------------------------------------------------------------------
    // stage 1: bank read in flight, sample side info alongside
    // ------------------------------------------------------------------
    logic [FRAC_BITS-1:0] r_s1_a, r_s1_b;
    logic                 r_s1_x0, r_s1_y0, r_s1_inb;

    always_ff @(posedge i_clk) begin
        if (smp_take) begin
            r_s1_a   <= smp_a;
            r_s1_b   <= smp_b;
            r_s1_x0  <= smp_x[0];
            r_s1_y0  <= smp_y[0];
            r_s1_inb <= smp_inb;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: horizontal blends of the top and bottom pixel pairs
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]     p00, p10, p01, p11;
    logic [FW-1:0]        wa0, wa1;
    logic [HW-1:0]        n_h0, n_h1;
    logic [HW-1:0]        r_s2_h0, r_s2_h1;
    logic [FRAC_BITS-1:0] r_s2_b;
    logic                 r_s2_inb;

    // undo the parity split so p00 is P(x,y)
    assign p00 = bank_data[{r_s1_y0, r_s1_x0}];
    assign p10 = bank_data[{r_s1_y0, ~r_s1_x0}];
    assign p01 = bank_data[{~r_s1_y0, r_s1_x0}];
    assign p11 = bank_data[{~r_s1_y0, ~r_s1_x0}];

    assign wa1  = FW'(r_s1_a);
    assign wa0  = ONE - wa1;
    assign n_h0 = HW'(HW'(wa0) * HW'(p00) + HW'(wa1) * HW'(p10));
    assign n_h1 = HW'(HW'(wa0) * HW'(p01) + HW'(wa1) * HW'(p11));

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_h0  <= n_h0;
            r_s2_h1  <= n_h1;
            r_s2_b   <= r_s1_b;
            r_s2_inb <= r_s1_inb;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: vertical blend, 2*FRAC_BITS fraction bits
    // ------------------------------------------------------------------
    logic [FW-1:0] wb0, wb1;
    logic [AW-1:0] n_acc, r_s3_acc;
    logic          r_s3_inb;

    assign wb1   = FW'(r_s2_b);
    assign wb0   = ONE - wb1;
    assign n_acc = AW'(AW'(wb0) * AW'(r_s2_h0) + AW'(wb1) * AW'(r_s2_h1));

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_s3_acc <= n_acc;
            r_s3_inb <= r_s2_inb;
        end
    end

    // ------------------------------------------------------------------
    // output register: scale to 16 fraction bits, zero when out of bounds
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] scaled;

    if (PF < OUT_FRAC) begin : g_scale_up
        assign scaled = OUT_W'(r_s3_acc) << (OUT_FRAC - PF);
    end else if (PF > OUT_FRAC) begin : g_scale_round
        localparam int RSH = PF - OUT_FRAC;
        logic [AW:0] rnd;
        // round half up
        assign rnd    = {1'b0, r_s3_acc} + ((AW + 1)'(1) << (RSH - 1));
        assign scaled = OUT_W'(rnd >> RSH);
    end else begin : g_scale_exact
        assign scaled = OUT_W'(r_s3_acc);
    end

    logic [OUT_W-1:0] n_sample_value;
    assign n_sample_value = r_s3_inb ? scaled : '0;

    logic [OUT_W-1:0] r_sample_value;
    logic             r_in_bounds;

    always_ff @(posedge i_clk) begin
        if (s3_move) begin
            r_sample_value <= n_sample_value;
            r_in_bounds    <= r_s3_inb;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (smp_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_move) begin
                r_s3_valid <= 1'b1;
            end else if (s3_move) begin
                r_s3_valid <= 1'b0;
            end
            if (s3_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_sample_value;
    assign o_in_bounds    = r_in_bounds;

endmodule

### design/bis_pixel_banks.sv
// four pixel banks split by column and row parity, registered read
// depends on bis_pkg
`timescale 1ns / 1ps

module bis_pixel_banks
    import bis_pkg::*;
#(
    parameter int ADDR_W = 14
) (
    input  logic                 i_clk,
    input  t_bank_ctl            i_ctl,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [PIX_W-1:0]     i_wr_data,
    input  logic [ADDR_W-1:0]    i_rd_addr [NUM_BANKS],
    output logic [PIX_W-1:0]     o_rd_data [NUM_BANKS]
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [PIX_W-1:0] r_rd_data [NUM_BANKS];

    for (genvar bk = 0; bk < NUM_BANKS; bk++) begin : g_bank
        logic [PIX_W-1:0] mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_ctl.wr_en && (i_ctl.wr_bank == 2'(bk))) begin
                mem[i_wr_addr] <= i_wr_data;
            end
        end

        // all four banks read together for one sample
        always_ff @(posedge i_clk) begin
            if (i_ctl.rd_en) begin
                r_rd_data[bk] <= mem[i_rd_addr[bk]];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/bis_checker.sv
// port-level checks of the bilinear image sampler, bound to the top level
// depends on bilinear_image_sampler_unit_macros.svh and bis_pkg
`timescale 1ns / 1ps
`include "bilinear_image_sampler_unit_macros.svh"

module bis_checker
    import bis_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [OUT_W-1:0]   o_sample_value,
    input logic               o_in_bounds
);

    // a stalled result stays offered
    `BIS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // and does not change under the stall
    `BIS_ASSERT(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_sample_value) && $stable(o_in_bounds), "result changed while stalled")

    // out-of-bounds samples carry a zero value
    `BIS_ASSERT(a_oob_zero, o_out_valid && !o_in_bounds |-> o_sample_value == '0, "out-of-bounds sample not zero")

    // blend never exceeds full-scale pixel
    `BIS_ASSERT(a_range, o_out_valid |-> o_sample_value <= 24'hFF0000, "sample above full scale")

    // no result right after reset
    `BIS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind bilinear_image_sampler_unit bis_checker u_bis_checker (.*);
